### rtl/integer_to_ascii_radix_assert.svh
// Assertion macros shared by the integer-to-ASCII checker
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// Check a property at every rising edge outside reset
`define ITOA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle leads to a consequence in the next
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/itoa_pkg.sv
// Shared constants, types and functions of the integer-to-ASCII converter
package itoa_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int NUMBER_W    = 16;
	localparam int CHAR_W      = 7;
	localparam int DIGIT_W     = 6;
	localparam int RADIX_W     = 6;
	localparam int IDX_W       = $clog2(VALUE_WIDTH);
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int DIV_CNT_W   = $clog2(VALUE_WIDTH);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(VALUE_WIDTH - 1);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	// register select is the word bit of the byte address
	localparam logic REG_RADIX = 1'b0;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] DECIMAL     = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_TEN   = 7'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} itoa_state_t;

	// control from the sequencer to the digit stack
	typedef struct packed {
		logic               clear;
		logic               neg;
		logic               push;
		logic [DIGIT_W-1:0] digit;
		logic               emit;
	} itoa_ctl_t;

	// clamp the radix register to 2..36
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		if (r < RADIX_MIN)
			return RADIX_MIN;
		else if (r > RADIX_MAX)
			return RADIX_MAX;
		else
			return r;
	endfunction

	// map a digit value to '0'..'9' or 'A'..'Z'
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = {1'b0, d};
		if (d < DECIMAL)
			return CHAR_ZERO + dw;
		else
			return CHAR_A + dw - CHAR_TEN;
	endfunction

endpackage

### rtl/itoa_if.sv
// Stream interfaces for the number input and the character output
interface itoa_num_if;
	import itoa_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [NUMBER_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

interface itoa_chr_if;
	import itoa_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

### rtl/integer_to_ascii_radix.sv
// Top level: integer to ASCII text in a configurable radix
//
//  channel | dir | handshake     | payload
//  num     | in  | valid/ready   | number (16-bit signed)
//  chr     | out | valid/ready   | character (7-bit ASCII), last
//  apb     | in  | psel/penable  | radix at byte address 0
//
// Each digit takes one pass of the bit-serial divider, so an item is split
// into D digits by D passes, then its characters (digits plus an optional
// minus) are loaded into the output register one after another.
// Radix 10 at 16 bits: at most 5 digits; radix 2: up to 16.
// Reset clears control state; the digit stack needs no clearing pass.
// A stalled sink holds the output register and the stack; no new number is taken
// until the last character has been loaded into the output register.
module integer_to_ascii_radix (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [itoa_pkg::PADDR_W-1:0] paddr,
	input  logic [itoa_pkg::PDATA_W-1:0] pwdata,
	output logic [itoa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	itoa_num_if.sink                    num,
	itoa_chr_if.source                  chr
);
	import itoa_pkg::*;

	itoa_state_t            state_q;
	itoa_state_t            state_nxt;
	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     base;
	logic [VALUE_WIDTH-1:0] value;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;

	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quo;
	logic [DIGIT_W-1:0]     div_rem;
	itoa_ctl_t              ctl;
	logic                   emit_done;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= RADIX_RESET;
		else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_RADIX)
			radix_q <= pwdata[RADIX_W-1:0];
	end

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1] == REG_RADIX) ? PDATA_W'(radix_q) : '0;

	// sign handling: minus only in decimal, magnitude taken unsigned
	always_comb begin
		base  = eff_radix(radix_q);
		value = num.number[VALUE_WIDTH-1:0];
		neg   = value[VALUE_WIDTH-1] && (base == DECIMAL);
		mag   = neg ? (~value + 1'b1) : value;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// next state and sequencing
	always_comb begin
		state_nxt    = state_q;
		num.ready    = 1'b0;
		div_start    = 1'b0;
		div_dividend = div_quo;
		ctl          = '0;
		ctl.neg      = neg;
		ctl.digit    = div_rem;
		unique case (state_q)
			ST_IDLE: begin
				num.ready = 1'b1;
				if (num.valid) begin
					div_start    = 1'b1;
					div_dividend = mag;
					ctl.clear    = 1'b1;
					state_nxt    = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					ctl.push = 1'b1;
					if (div_quo == '0)
						state_nxt = ST_EMIT;
					else
						div_start = 1'b1;
				end
			end
			ST_EMIT: begin
				ctl.emit = 1'b1;
				if (emit_done)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	itoa_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (base),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	itoa_emitter u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.done   (emit_done),
		.chr    (chr)
	);

endmodule

### rtl/itoa_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle
module itoa_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [itoa_pkg::VALUE_WIDTH-1:0] dividend,
	input  logic [itoa_pkg::RADIX_W-1:0]  divisor,
	output logic                          done,
	output logic [itoa_pkg::VALUE_WIDTH-1:0] quotient,
	output logic [itoa_pkg::DIGIT_W-1:0]  remainder
);
	import itoa_pkg::*;

	logic                   run_q;
	logic                   done_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]     rem_q;

	logic [DIGIT_W:0]       trial;
	logic [DIGIT_W:0]       diff;
	logic                   ge;
	logic [DIGIT_W-1:0]     rem_nxt;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		trial   = {rem_q, quo_q[VALUE_WIDTH-1]};
		diff    = trial - {1'b0, divisor};
		ge      = trial >= {1'b0, divisor};
		rem_nxt = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
	end

	// sequence one bit per cycle and flag the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hold partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### rtl/itoa_emitter.sv
// Digit stack and character output register
module itoa_emitter (
	input  logic                clk,
	input  logic                arst_n,
	input  itoa_pkg::itoa_ctl_t ctl,
	output logic                done,
	itoa_chr_if.source          chr
);
	import itoa_pkg::*;

	logic [DIGIT_W-1:0] store_q [VALUE_WIDTH];
	logic [CNT_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   ptr_q;
	logic               sign_q;
	logic               ovalid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic               load;
	logic               last_nxt;
	logic [CHAR_W-1:0]  char_nxt;

	// pick the next character: sign first, then digits from the top
	always_comb begin
		load     = ctl.emit && (!ovalid_q || chr.ready);
		last_nxt = !sign_q && (ptr_q == '0);
		char_nxt = sign_q ? CHAR_MINUS : digit_char(store_q[ptr_q]);
	end

	assign done = load && last_nxt;

	// write digits, least significant first
	always_ff @(posedge clk) begin
		if (ctl.push)
			store_q[cnt_q[IDX_W-1:0]] <= ctl.digit;
	end

	// track fill level, read pointer and pending sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ptr_q  <= '0;
			sign_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				cnt_q  <= '0;
				sign_q <= ctl.neg;
			end else if (ctl.push) begin
				cnt_q <= cnt_q + 1'b1;
				ptr_q <= cnt_q[IDX_W-1:0];
			end else if (load) begin
				if (sign_q)
					sign_q <= 1'b0;
				else
					ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (load)
			ovalid_q <= 1'b1;
		else if (chr.ready)
			ovalid_q <= 1'b0;
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= char_nxt;
			last_q <= last_nxt;
		end
	end

	assign chr.valid     = ovalid_q;
	assign chr.character = char_q;
	assign chr.last      = last_q;

endmodule

### rtl/itoa_checker.sv
// Port-level checks for the integer-to-ASCII converter, bound to the top level
`include "integer_to_ascii_radix_assert.svh"

module itoa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        num_valid,
	input logic                        num_ready,
	input logic                        chr_valid,
	input logic                        chr_ready,
	input logic [itoa_pkg::CHAR_W-1:0] chr_character,
	input logic                        chr_last
);
	import itoa_pkg::*;

	logic [CHAR_W:0] chr_beat;
	logic            chr_stall;
	logic            chr_minus;
	logic            chr_legal;

	// gather the character beat and classify its code
	always_comb begin
		chr_beat  = {chr_character, chr_last};
		chr_stall = chr_valid && !chr_ready;
		chr_minus = (chr_character == CHAR_MINUS);
		chr_legal = chr_minus
			|| ((chr_character >= 7'h30) && (chr_character <= 7'h39))
			|| ((chr_character >= 7'h41) && (chr_character <= 7'h5A));
	end

	// a stalled beat keeps its payload
	`ITOA_ASSERT_NEXT(a_hold, chr_stall, chr_valid && $stable(chr_beat), "stalled beat changed")

	// one number at a time: conversion starts right after acceptance
	`ITOA_ASSERT_NEXT(a_busy, num_valid && num_ready, !num_ready, "input taken while converting")

	// only digits, upper-case letters and minus leave the block
	`ITOA_ASSERT(a_charset, chr_valid |-> chr_legal, "character outside the digit set")

	// a minus sign always leads digits
	`ITOA_ASSERT(a_minus, chr_valid && chr_minus |-> !chr_last, "minus sign marked last")

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.num_valid     (num.valid),
	.num_ready     (num.ready),
	.chr_valid     (chr.valid),
	.chr_ready     (chr.ready),
	.chr_character (chr.character),
	.chr_last      (chr.last)
);
